// File: rtl/core/uart_rx_command_decoder_unit_defines.svh
// Assertion helpers shared by the receiver RTL.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef UART_RX_COMMAND_DECODER_UNIT_DEFINES_SVH
`define UART_RX_COMMAND_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define URCD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("urcd assertion failed");

// Next-cycle implication.
`define URCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("urcd assertion failed");

`endif

// File: rtl/core/urcd_pkg.sv
`timescale 1ns / 1ps

package urcd_pkg;

	// Receiver phases.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_DATA  = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HALF_BIT_TICKS = 2'd0;
	localparam logic [1:0] CFG_BIT_TICKS      = 2'd1;
	localparam logic [1:0] CFG_STOP_LEVEL     = 2'd2;

	localparam int unsigned TICK_W = 16;

	localparam logic [TICK_W-1:0] HALF_BIT_TICKS_RST = 16'd14;
	localparam logic [TICK_W-1:0] BIT_TICKS_RST      = 16'd27;

	// Command bytes.
	localparam logic [7:0] CMD_LAMP_A_ON  = 8'h01;
	localparam logic [7:0] CMD_LAMP_A_OFF = 8'h0A;
	localparam logic [7:0] CMD_LAMP_B_ON  = 8'h10;
	localparam logic [7:0] CMD_LAMP_B_OFF = 8'hA0;

	// Frame event from the receiver to the command decoder and output stage.
	typedef struct packed {
		logic       done;
		logic       ferr;
		logic [7:0] data;
		logic       receiving;
	} rx_evt_t;

	// Lamp and last-byte state after the current sample.
	typedef struct packed {
		logic       lamp_a;
		logic       lamp_b;
		logic [7:0] held;
	} dec_state_t;

endpackage

// File: rtl/core/urcd_rx_core.sv
`timescale 1ns / 1ps

// Frame receiver: start-bit check, data bit sampling and stop-bit check.
// evt shows the outcome of the sample on level when adv is high.
module urcd_rx_core #(
	parameter int unsigned DATA_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          level,
	input  logic [urcd_pkg::TICK_W-1:0]   half_bit_ticks,
	input  logic [urcd_pkg::TICK_W-1:0]   bit_ticks,
	input  logic                          stop_level,
	output urcd_pkg::rx_evt_t             evt
);

	urcd_pkg::phase_t phase_q, phase_d;
	logic [urcd_pkg::TICK_W-1:0] tick_q, tick_d, tick_inc, limit;
	logic [3:0] bits_q, bits_d, bits_inc;
	logic [7:0] shift_q, shift_d;
	logic prev_q;
	logic reached;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= urcd_pkg::PH_IDLE;
			tick_q  <= '0;
			bits_q  <= '0;
			shift_q <= '0;
			prev_q  <= 1'b1;
		end else if (adv) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			prev_q  <= level;
		end
	end

	assign tick_inc = tick_q + 16'd1;
	assign limit    = (phase_q == urcd_pkg::PH_START) ? half_bit_ticks : bit_ticks;
	// A limit of zero fires on the next tick, as does a counter wrap.
	assign reached  = (tick_inc >= limit) || (tick_inc == '0);
	assign bits_inc = bits_q + 4'd1;

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bits_d   = bits_q;
		shift_d  = shift_q;
		evt.done = 1'b0;
		evt.ferr = 1'b0;
		unique case (phase_q)
			urcd_pkg::PH_IDLE: begin
				if (prev_q && !level) begin
					phase_d = urcd_pkg::PH_START;
					tick_d  = '0;
					bits_d  = '0;
					shift_d = '0;
				end
			end
			urcd_pkg::PH_START: begin
				tick_d = reached ? '0 : tick_inc;
				if (reached) begin
					phase_d = level ? urcd_pkg::PH_IDLE : urcd_pkg::PH_DATA;
				end
			end
			urcd_pkg::PH_DATA: begin
				tick_d = reached ? '0 : tick_inc;
				if (reached) begin
					shift_d = (shift_q >> 1) | (8'(level) << (DATA_BITS - 1));
					bits_d  = bits_inc;
					if (bits_inc >= 4'(DATA_BITS)) begin
						phase_d = urcd_pkg::PH_STOP;
					end
				end
			end
			urcd_pkg::PH_STOP: begin
				tick_d = reached ? '0 : tick_inc;
				if (reached) begin
					evt.done = (level == stop_level);
					evt.ferr = (level != stop_level);
					phase_d  = urcd_pkg::PH_IDLE;
					bits_d   = '0;
				end
			end
			default: begin
				phase_d = urcd_pkg::PH_IDLE;
			end
		endcase
		evt.data      = shift_q;
		evt.receiving = (phase_d != urcd_pkg::PH_IDLE);
	end

endmodule

// File: rtl/core/urcd_cmd_dec.sv
`timescale 1ns / 1ps

// Command decoder: keeps the lamp states and the last good byte.
// st_next is the state after the current sample.
module urcd_cmd_dec (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  urcd_pkg::rx_evt_t      evt,
	output urcd_pkg::dec_state_t   st_next
);

	urcd_pkg::dec_state_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_comb begin
		st_next = st_q;
		if (evt.done) begin
			st_next.held = evt.data;
			unique case (evt.data)
				urcd_pkg::CMD_LAMP_A_ON:  st_next.lamp_a = 1'b1;
				urcd_pkg::CMD_LAMP_A_OFF: st_next.lamp_a = 1'b0;
				urcd_pkg::CMD_LAMP_B_ON:  st_next.lamp_b = 1'b1;
				urcd_pkg::CMD_LAMP_B_OFF: st_next.lamp_b = 1'b0;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/uart_rx_command_decoder_unit.sv
`timescale 1ns / 1ps

// Serial receiver with command decoder. Each input transfer carries one sample
// of the receive line (line_level); each sample yields exactly one output
// transfer with the lamp states, the byte_done and frame_error pulses, the last
// good byte and the receiving flag as they stand after that sample.
// Both channels use valid/stall handshakes. A sample lands in an input register,
// is processed by the frame receiver and command decoder once the output register
// is free or draining, and is then written to the output register, which holds
// the result with out_valid high until the output side takes it. One sample is
// accepted per cycle for as long as the output side keeps taking results.
// When out_stall holds the output register, in_stall rises only once the input
// register is also occupied, so at most two samples are in flight.
// Reset (arst_n low) empties both registers, sets the receiver to idle with the
// previous line level high, turns both lamps off, clears the held byte and loads
// the default bit timing. Configuration writes via cfg_we/cfg_index/cfg_data
// take effect at once and are meant to occur while no sample is in flight.
module uart_rx_command_decoder_unit #(
	parameter int unsigned DATA_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        line_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        lamp_a,
	output logic        lamp_b,
	output logic        byte_done,
	output logic [7:0]  byte_value,
	output logic        frame_error,
	output logic        receiving
);

	`include "uart_rx_command_decoder_unit_defines.svh"

	logic [urcd_pkg::TICK_W-1:0] half_bit_ticks_q, bit_ticks_q;
	logic stop_level_q;

	logic valid_s1, level_s1;
	logic out_valid_q;
	logic adv;

	urcd_pkg::rx_evt_t    evt;
	urcd_pkg::dec_state_t dec_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_ticks_q <= urcd_pkg::HALF_BIT_TICKS_RST;
			bit_ticks_q      <= urcd_pkg::BIT_TICKS_RST;
			stop_level_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				urcd_pkg::CFG_HALF_BIT_TICKS: half_bit_ticks_q <= cfg_data;
				urcd_pkg::CFG_BIT_TICKS:      bit_ticks_q      <= cfg_data;
				urcd_pkg::CFG_STOP_LEVEL:     stop_level_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A held sample moves on whenever the output register is free or draining.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= line_level;
		end
	end

	urcd_rx_core #(
		.DATA_BITS(DATA_BITS)
	) u_rx_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.level         (level_s1),
		.half_bit_ticks(half_bit_ticks_q),
		.bit_ticks     (bit_ticks_q),
		.stop_level    (stop_level_q),
		.evt           (evt)
	);

	urcd_cmd_dec u_cmd_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.evt    (evt),
		.st_next(dec_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lamp_a      <= dec_next.lamp_a;
			lamp_b      <= dec_next.lamp_b;
			byte_done   <= evt.done;
			byte_value  <= dec_next.held;
			frame_error <= evt.ferr;
			receiving   <= evt.receiving;
		end
	end

	assign out_valid = out_valid_q;

	// A frame ends either good or bad, never both.
	`URCD_ASSERT_IMP(a_done_xor_err, out_valid_q, !(byte_done && frame_error))
	// A completed or failed frame leaves the receiver idle.
	`URCD_ASSERT_IMP(a_end_idle, out_valid_q && (byte_done || frame_error), !receiving)
	// The input side stalls only when both registers are full and blocked.
	`URCD_ASSERT_IMP(a_stall_full, in_stall, valid_s1 && out_valid_q && out_stall)
	// An advanced sample always lands in the output register.
	`URCD_ASSERT_NEXT(a_adv_lands, adv, out_valid_q)

endmodule

// File: tb/sv/uart_rx_command_decoder_unit_test.sv
`timescale 1ns / 1ps

module uart_rx_command_decoder_unit_test;

	localparam int DATA_BITS = 8;
	// The slowest legal run (every sample held off by both sides) stays far below this.
	localparam int CYCLE_LIMIT = 4_000_000;
	// Length of the single long receiver hold-off that fills the block.
	localparam int HOLD_CYCLES = 300;

	// One result transfer, in the order of the output ports.
	typedef struct packed {
		logic       lamp_a;
		logic       lamp_b;
		logic       byte_done;
		logic [7:0] byte_value;
		logic       frame_error;
		logic       receiving;
	} rx_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = urcd_pkg::CFG_HALF_BIT_TICKS;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        line_level = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        lamp_a;
	logic        lamp_b;
	logic        byte_done;
	logic [7:0]  byte_value;
	logic        frame_error;
	logic        receiving;

	uart_rx_command_decoder_unit #(
		.DATA_BITS(DATA_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.line_level(line_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.lamp_a(lamp_a),
		.lamp_b(lamp_b),
		.byte_done(byte_done),
		.byte_value(byte_value),
		.frame_error(frame_error),
		.receiving(receiving)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Line samples waiting to be sent, and the results predicted for accepted samples.
	logic       line_samples[$];
	rx_result_t expected_results[$];

	int samples_queued = 0;
	int samples_taken = 0;
	int good_frames = 0;
	int frame_errors = 0;
	int mismatches = 0;
	int settings_used = 1;

	// Set by the stimulus process: calm turns off all idling for the final part,
	// press_arm asks the receiver side for its one long hold-off.
	bit calm = 1'b0;
	bit press_arm = 1'b0;

	// Acceptance seen at the latest rising edge, read by the driver at the falling edge.
	bit in_took = 1'b0;

	// ------------------------------------------------------------------
	// Predictor state. The configuration copy follows every register write;
	// the rest mirrors the receiver and the command decoder after reset.
	// ------------------------------------------------------------------
	logic [15:0] cfg_half = urcd_pkg::HALF_BIT_TICKS_RST;
	logic [15:0] cfg_bit = urcd_pkg::BIT_TICKS_RST;
	logic        cfg_stop = 1'b0;

	urcd_pkg::phase_t rx_phase = urcd_pkg::PH_IDLE;
	logic [15:0] tick_cnt = '0;
	logic [3:0]  bit_cnt = '0;
	logic [7:0]  shreg = '0;
	logic        last_level = 1'b1;
	logic        lamp_a_on = 1'b0;
	logic        lamp_b_on = 1'b0;
	logic [7:0]  held_byte = '0;

	// Advances the tick counter and tells whether this tick is a sample point.
	// A limit of zero acts like one because the counter never equals zero after
	// the increment unless it wraps.
	function automatic bit tick_due(input logic [15:0] limit);
		tick_cnt = tick_cnt + 16'd1;
		if (tick_cnt >= limit || tick_cnt == 16'd0) begin
			tick_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Works out the result that one accepted line sample produces.
	task automatic decode_sample(input logic lv, output rx_result_t r);
		r.byte_done = 1'b0;
		r.frame_error = 1'b0;
		case (rx_phase)
			urcd_pkg::PH_IDLE: begin
				// Only a high-to-low step starts a frame.
				if (last_level && !lv) begin
					rx_phase = urcd_pkg::PH_START;
					tick_cnt = '0;
					bit_cnt = '0;
					shreg = '0;
				end
			end
			urcd_pkg::PH_START: begin
				// A start bit that reads high at its middle is a glitch: back to idle.
				if (tick_due(cfg_half)) begin
					rx_phase = lv ? urcd_pkg::PH_IDLE : urcd_pkg::PH_DATA;
				end
			end
			urcd_pkg::PH_DATA: begin
				// Least significant bit first, shifted in from the top of the word.
				if (tick_due(cfg_bit)) begin
					shreg = (shreg >> 1) | (8'(lv) << (DATA_BITS - 1));
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= DATA_BITS) begin
						rx_phase = urcd_pkg::PH_STOP;
					end
				end
			end
			default: begin
				if (tick_due(cfg_bit)) begin
					if (lv == cfg_stop) begin
						r.byte_done = 1'b1;
						held_byte = shreg;
						case (held_byte)
							urcd_pkg::CMD_LAMP_A_ON:  lamp_a_on = 1'b1;
							urcd_pkg::CMD_LAMP_A_OFF: lamp_a_on = 1'b0;
							urcd_pkg::CMD_LAMP_B_ON:  lamp_b_on = 1'b1;
							urcd_pkg::CMD_LAMP_B_OFF: lamp_b_on = 1'b0;
							default: ;
						endcase
					end else begin
						// Wrong stop level: the byte is dropped and the lamps stay as they are.
						r.frame_error = 1'b1;
					end
					rx_phase = urcd_pkg::PH_IDLE;
					bit_cnt = '0;
				end
			end
		endcase
		last_level = lv;
		r.lamp_a = lamp_a_on;
		r.lamp_b = lamp_b_on;
		r.byte_value = held_byte;
		r.receiving = (rx_phase != urcd_pkg::PH_IDLE);
	endtask

	// ------------------------------------------------------------------
	// Sender. Inputs change at the falling edge. A sample that is offered
	// stays put until it has been accepted; between samples the sender may
	// pause at random.
	// ------------------------------------------------------------------
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// Stalled: hold valid and the payload.
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			gap_left <= $urandom_range(0, 18);
			in_valid <= 1'b0;
		end else if (line_samples.size() > 0) begin
			in_valid <= 1'b1;
			line_level <= line_samples.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Receiver side. Random stall bursts, plus one long hold-off, counted here,
	// while the sender keeps offering samples so that both internal registers
	// fill and the block stalls its input.
	// ------------------------------------------------------------------
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (press_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Monitor. At each rising edge an accepted sample is run through the
	// predictor, and an accepted result is checked against the oldest
	// prediction still waiting.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rx_result_t want;
		rx_result_t got;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				decode_sample(line_level, want);
				expected_results.push_back(want);
				samples_taken++;
			end
			if (out_valid && !out_stall) begin
				got = {lamp_a, lamp_b, byte_done, byte_value, frame_error, receiving};
				if (got.byte_done) good_frames++;
				if (got.frame_error) frame_errors++;
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result transfer with no sample pending:", $time);
					$display("%0t:   actual a=%b b=%b done=%b byte=%h ferr=%b rx=%b",
						$time, got.lamp_a, got.lamp_b, got.byte_done, got.byte_value,
						got.frame_error, got.receiving);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: expected a=%b b=%b done=%b byte=%h ferr=%b rx=%b",
							$time, want.lamp_a, want.lamp_b, want.byte_done, want.byte_value,
							want.frame_error, want.receiving);
						$display("%0t:   actual a=%b b=%b done=%b byte=%h ferr=%b rx=%b",
							$time, got.lamp_a, got.lamp_b, got.byte_done, got.byte_value,
							got.frame_error, got.receiving);
					end
				end
			end
		end
	end

	// The run ends here if it ever hangs.
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	task automatic put(input logic lv);
		line_samples.push_back(lv);
		samples_queued++;
	endtask

	// Effective tick count of a timing register: zero behaves as one.
	function automatic int span(input logic [15:0] v);
		return (v == 16'd0) ? 1 : int'(v);
	endfunction

	// Queues one frame for the current timing: lead idle-high samples, the
	// falling edge, the start bit, then data and stop bits. In a noisy frame
	// every tick after the falling edge that is not a sample point carries a
	// random level. A frame with a bad start bit ends at the start sample point.
	task automatic push_frame(input int lead, input logic [7:0] data, input bit start_ok,
			input bit stop_ok, input bit noisy);
		int h;
		int b;
		int i;
		int k;
		logic stop_bit;
		h = span(cfg_half);
		b = span(cfg_bit);
		stop_bit = stop_ok ? cfg_stop : ~cfg_stop;
		for (i = 0; i < lead; i++) put(1'b1);
		put(1'b0);
		for (i = 1; i < h; i++) put(noisy ? 1'($urandom_range(0, 1)) : 1'b0);
		put(start_ok ? 1'b0 : 1'b1);
		if (start_ok) begin
			for (k = 0; k < DATA_BITS; k++) begin
				for (i = 1; i <= b; i++) begin
					put((noisy && i < b) ? 1'($urandom_range(0, 1)) : data[k]);
				end
			end
			for (i = 1; i <= b; i++) begin
				put((noisy && i < b) ? 1'($urandom_range(0, 1)) : stop_bit);
			end
		end
	endtask

	// Mostly well-formed frames with random content and commands; the rest
	// are bad stop bits, glitched start bits and plain line noise.
	task automatic random_traffic(input int budget);
		int start_cnt;
		int pick;
		int lead;
		int i;
		logic [7:0] data;
		logic [7:0] commands[4];
		commands = '{urcd_pkg::CMD_LAMP_A_ON, urcd_pkg::CMD_LAMP_A_OFF,
			urcd_pkg::CMD_LAMP_B_ON, urcd_pkg::CMD_LAMP_B_OFF};
		start_cnt = samples_queued;
		while (samples_queued - start_cnt < budget) begin
			pick = $urandom_range(0, 99);
			lead = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
			data = ($urandom_range(0, 9) < 4) ? commands[$urandom_range(0, 3)] : 8'($urandom);
			if (pick < 75) begin
				push_frame(lead, data, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
			end else if (pick < 85) begin
				push_frame(lead, data, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
			end else if (pick < 93) begin
				push_frame(lead, data, 1'b0, 1'b1, 1'($urandom_range(0, 1)));
			end else begin
				for (i = $urandom_range(1, 8); i > 0; i--) put(1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Waits until every queued sample has been taken and every predicted
	// result has come back, then lets the two-stage pipeline settle.
	task automatic drain();
		while (samples_taken != samples_queued || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (6) @(negedge clk);
	endtask

	// Register writes happen at the falling edge and are mirrored into the
	// predictor; upper bits of the stop level write are ignored by the block.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			urcd_pkg::CFG_HALF_BIT_TICKS: cfg_half = value;
			urcd_pkg::CFG_BIT_TICKS:      cfg_bit = value;
			urcd_pkg::CFG_STOP_LEVEL:     cfg_stop = value[0];
			default: ;
		endcase
	endtask

	// Changes the timing only once the block has nothing in flight.
	task automatic new_setting(input logic [15:0] half, input logic [15:0] full,
			input logic [15:0] stop_raw);
		drain();
		write_reg(urcd_pkg::CFG_HALF_BIT_TICKS, half);
		write_reg(urcd_pkg::CFG_BIT_TICKS, full);
		write_reg(urcd_pkg::CFG_STOP_LEVEL, stop_raw);
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset timing: a lamp command, a bad stop bit that must leave the
		// lamp alone, and a start bit that turns out to be a glitch.
		push_frame(2, urcd_pkg::CMD_LAMP_A_ON, 1'b1, 1'b1, 1'b0);
		push_frame(2, urcd_pkg::CMD_LAMP_A_OFF, 1'b1, 1'b0, 1'b0);
		push_frame(2, 8'h00, 1'b0, 1'b1, 1'b1);

		// Zero tick counts act as one; stop level high, written with junk in the
		// upper bits. Every command, unknown bytes, the extreme bytes and a frame
		// that starts right on the heels of the previous stop bit.
		new_setting(16'd0, 16'd0, 16'hFFFF);
		push_frame(1, urcd_pkg::CMD_LAMP_B_ON, 1'b1, 1'b1, 1'b0);
		push_frame(1, urcd_pkg::CMD_LAMP_A_ON, 1'b1, 1'b1, 1'b0);
		push_frame(0, urcd_pkg::CMD_LAMP_B_OFF, 1'b1, 1'b1, 1'b0);
		push_frame(2, urcd_pkg::CMD_LAMP_A_OFF, 1'b1, 1'b1, 1'b0);
		push_frame(1, 8'h5A, 1'b1, 1'b1, 1'b0);
		push_frame(1, 8'h00, 1'b1, 1'b1, 1'b0);
		push_frame(0, 8'hFF, 1'b1, 1'b1, 1'b0);
		push_frame(1, urcd_pkg::CMD_LAMP_B_ON, 1'b1, 1'b0, 1'b0);
		push_frame(1, 8'hC3, 1'b0, 1'b1, 1'b0);
		push_frame(1, urcd_pkg::CMD_LAMP_A_ON, 1'b1, 1'b1, 1'b1);

		// Short bit times, stop level low, with the long receiver hold-off.
		new_setting(16'd1, 16'd2, 16'd0);
		random_traffic(300);
		press_arm = 1'b1;

		new_setting(16'd3, 16'd5, 16'hFFFE | 16'd1);
		random_traffic(300);

		// Long half bit against a one-tick bit period: one clean frame.
		new_setting(16'd40, 16'd1, 16'd1);
		push_frame(2, urcd_pkg::CMD_LAMP_B_ON, 1'b1, 1'b1, 1'b0);

		// Longest bit period: only glitched start bits, so no frame has to
		// sit out a full data bit.
		new_setting(16'd2, 16'hFFFF, 16'd0);
		repeat (30) push_frame($urandom_range(1, 4), 8'h00, 1'b0, 1'b1, 1'b1);

		// Final part with no idling on either side.
		new_setting(16'd2, 16'd3, 16'd0);
		calm = 1'b1;
		random_traffic(300);

		drain();
		$display("Sent %0d line samples under %0d timing settings.", samples_taken,
			settings_used);
		$display("Saw %0d good frames and %0d stop-bit errors.", good_frames, frame_errors);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/urcd_pkg.sv
rtl/core/urcd_rx_core.sv
rtl/core/urcd_cmd_dec.sv
rtl/core/uart_rx_command_decoder_unit.sv
tb/sv/uart_rx_command_decoder_unit_test.sv
